@@ sv/cone_beam_voxel_backprojection_defines.svh @@
// assertion macros shared by the backprojection rtl
// used by cbvb_ctrl and cbvb_datapath, which expect clk and rst_n in scope
`ifndef CONE_BEAM_VOXEL_BACKPROJECTION_DEFINES_SVH
`define CONE_BEAM_VOXEL_BACKPROJECTION_DEFINES_SVH

// property must hold at every clock edge out of reset
`define CBVB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define CBVB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/cbvb_pkg.sv @@
// shared constants, types and command/status structs of the backprojection engine
// no dependencies
`timescale 1ns / 1ps

package cbvb_pkg;

  localparam int IMAGE_WIDTH  = 64;
  localparam int IMAGE_HEIGHT = 64;

  localparam int IDX_W  = 6;
  localparam int SD_W   = 24;
  localparam int UOF_W  = 16;
  localparam int PIX_W  = 24;
  localparam int TRIG_W = 16;
  localparam int VAL_W  = 32;

  localparam int IMG_DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int VOL_DEPTH = IMAGE_WIDTH * IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int IMG_AW    = $clog2(IMG_DEPTH);
  localparam int VOL_AW    = $clog2(VOL_DEPTH);

  localparam int ANG_SHIFT = 14;
  localparam int FRAC_W    = 8;
  localparam int CRD_W     = 18;
  localparam int PRD_W     = CRD_W + TRIG_W;
  localparam int SQ_W      = 2 * CRD_W + 1;
  localparam int T_W       = PRD_W + 2;
  localparam int NUM_W     = T_W + SD_W;
  localparam int DEN_W     = SD_W + ANG_SHIFT + 2;
  localparam int Q_W       = NUM_W + 1;
  localparam int M_W       = Q_W + 1;
  localparam int CNT_W     = $clog2(NUM_W);
  localparam int WGT_W     = FRAC_W + 2;
  localparam int A_W       = PIX_W + WGT_W + 1;
  localparam int R_W       = A_W + WGT_W + 1;
  localparam int SUM_W     = VAL_W + 2;

  localparam int    CYL_MARGIN     = 3;
  localparam int    EDGE_MARGIN_Q8 = 26;
  localparam longint CYL_R  = longint'(IMAGE_WIDTH) * 128 - CYL_MARGIN * 256;
  localparam longint CYL_R2 = CYL_R * CYL_R;
  localparam longint UMAX   = longint'(IMAGE_WIDTH - 1) * 256 - EDGE_MARGIN_Q8;
  localparam longint VMAX   = longint'(IMAGE_HEIGHT - 1) * 256 - EDGE_MARGIN_Q8;

  localparam logic [SD_W-1:0]  SD_RESET  = SD_W'(256000);
  localparam logic [UOF_W-1:0] UOF_RESET = '0;

  localparam int REG_SD  = 0;
  localparam int REG_UOF = 1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BPROJ = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    STEP_IDLE, STEP_CLR, STEP_VRD, STEP_DISP,
    STEP_GEO1, STEP_GEO2, STEP_GEO3, STEP_GEO4, STEP_TST,
    STEP_MUL, STEP_DINU, STEP_DIVU, STEP_DINV, STEP_DIVV, STEP_CHK,
    STEP_PRD0, STEP_PRD1, STEP_PRD2, STEP_PRD3, STEP_PRDW,
    STEP_BL1, STEP_BL2, STEP_BL3, STEP_ACC, STEP_OUT
  } step_t;

  typedef struct packed {
    step_t step;
    logic  accept;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
    logic geo_ok;
    logic iter_last;
    logic clr_last;
    logic det_ok;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [SD_W-1:0]         sd;
    logic signed [UOF_W-1:0] uoff;
  } cfg_t;

endpackage

@@ sv/cbvb_ram.sv @@
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cbvb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/cbvb_ctrl.sv @@
// sequencing state machine of the backprojection engine
// depends on cbvb_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "cone_beam_voxel_backprojection_defines.svh"

module cbvb_ctrl
  import cbvb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [24:0] {
    ST_CLR  = 25'd1 << 0,
    ST_IDLE = 25'd1 << 1,
    ST_VRD  = 25'd1 << 2,
    ST_DISP = 25'd1 << 3,
    ST_GEO1 = 25'd1 << 4,
    ST_GEO2 = 25'd1 << 5,
    ST_GEO3 = 25'd1 << 6,
    ST_GEO4 = 25'd1 << 7,
    ST_TST  = 25'd1 << 8,
    ST_MUL  = 25'd1 << 9,
    ST_DINU = 25'd1 << 10,
    ST_DIVU = 25'd1 << 11,
    ST_DINV = 25'd1 << 12,
    ST_DIVV = 25'd1 << 13,
    ST_CHK  = 25'd1 << 14,
    ST_PRD0 = 25'd1 << 15,
    ST_PRD1 = 25'd1 << 16,
    ST_PRD2 = 25'd1 << 17,
    ST_PRD3 = 25'd1 << 18,
    ST_PRDW = 25'd1 << 19,
    ST_BL1  = 25'd1 << 20,
    ST_BL2  = 25'd1 << 21,
    ST_BL3  = 25'd1 << 22,
    ST_ACC  = 25'd1 << 23,
    ST_OUT  = 25'd1 << 24
  } state_t;

  state_t state_r, state_nxt;
  step_t  step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step      = STEP_IDLE;
    unique case (state_r)
      ST_CLR: begin
        step = STEP_CLR;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        step = STEP_IDLE;
        if (in_tvalid) state_nxt = ST_VRD;
      end
      ST_VRD: begin
        step      = STEP_VRD;
        state_nxt = ST_DISP;
      end
      ST_DISP: begin
        step      = STEP_DISP;
        state_nxt = (sts.op == OP_BPROJ && sts.in_range) ? ST_GEO1 : ST_OUT;
      end
      ST_GEO1: begin
        step      = STEP_GEO1;
        state_nxt = ST_GEO2;
      end
      ST_GEO2: begin
        step      = STEP_GEO2;
        state_nxt = ST_GEO3;
      end
      ST_GEO3: begin
        step      = STEP_GEO3;
        state_nxt = ST_GEO4;
      end
      ST_GEO4: begin
        step      = STEP_GEO4;
        state_nxt = ST_TST;
      end
      ST_TST: begin
        step      = STEP_TST;
        state_nxt = sts.geo_ok ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        step = STEP_MUL;
        if (sts.iter_last) state_nxt = ST_DINU;
      end
      ST_DINU: begin
        step      = STEP_DINU;
        state_nxt = ST_DIVU;
      end
      ST_DIVU: begin
        step = STEP_DIVU;
        if (sts.iter_last) state_nxt = ST_DINV;
      end
      ST_DINV: begin
        step      = STEP_DINV;
        state_nxt = ST_DIVV;
      end
      ST_DIVV: begin
        step = STEP_DIVV;
        if (sts.iter_last) state_nxt = ST_CHK;
      end
      ST_CHK: begin
        step      = STEP_CHK;
        state_nxt = sts.det_ok ? ST_PRD0 : ST_OUT;
      end
      ST_PRD0: begin
        step      = STEP_PRD0;
        state_nxt = ST_PRD1;
      end
      ST_PRD1: begin
        step      = STEP_PRD1;
        state_nxt = ST_PRD2;
      end
      ST_PRD2: begin
        step      = STEP_PRD2;
        state_nxt = ST_PRD3;
      end
      ST_PRD3: begin
        step      = STEP_PRD3;
        state_nxt = ST_PRDW;
      end
      ST_PRDW: begin
        step      = STEP_PRDW;
        state_nxt = ST_BL1;
      end
      ST_BL1: begin
        step      = STEP_BL1;
        state_nxt = ST_BL2;
      end
      ST_BL2: begin
        step      = STEP_BL2;
        state_nxt = ST_BL3;
      end
      ST_BL3: begin
        step      = STEP_BL3;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        step      = STEP_ACC;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        step = STEP_OUT;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        step      = STEP_IDLE;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cmd.step   = step;
  assign cmd.accept = in_tready && in_tvalid;

  `CBVB_ASSERT(a_accept_reads, cmd.accept |=> state_r == ST_VRD, "accept not followed by voxel read")
  `CBVB_ASSERT(a_div_holds, (state_r == ST_DIVU && !sts.iter_last) |=> state_r == ST_DIVU,
               "divider left before last iteration")
  `CBVB_ASSERT_NEVER(a_no_accept_clr, state_r == ST_CLR && in_tready, "ready during clear pass")

endmodule

@@ sv/cbvb_datapath.sv @@
// datapath: image and voxel memories, geometry, shift-add multiplier,
// restoring divider, bilinear blend and output register; depends on cbvb_pkg, cbvb_ram
`timescale 1ns / 1ps
`include "cone_beam_voxel_backprojection_defines.svh"

module cbvb_datapath
  import cbvb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  cfg_t                     cfg,
  input  op_t                      in_op,
  input  logic [IDX_W-1:0]         in_col,
  input  logic [IDX_W-1:0]         in_row,
  input  logic signed [PIX_W-1:0]  in_pval,
  input  logic [IDX_W-1:0]         in_vx,
  input  logic [IDX_W-1:0]         in_vy,
  input  logic [IDX_W-1:0]         in_vz,
  input  logic signed [TRIG_W-1:0] in_sin,
  input  logic signed [TRIG_W-1:0] in_cos,
  input  logic signed [UOF_W-1:0]  in_hoff,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [VAL_W-1:0]         out_value,
  output logic                     out_upd,
  output logic                     out_sat
);

  // latched transaction
  op_t                      op_r;
  logic [IDX_W-1:0]         col_r, row_r, vx_r, vy_r, vz_r;
  logic signed [PIX_W-1:0]  pval_r;
  logic signed [TRIG_W-1:0] sin_r, cos_r;
  logic signed [UOF_W-1:0]  hoff_r;

  logic [VOL_AW-1:0] clr_addr_r;
  logic [CNT_W-1:0]  cnt_r;

  logic signed [PRD_W-1:0] pa_r, pb_r;
  logic signed [SQ_W-1:0]  sq_r;
  logic signed [T_W-1:0]   t_r;
  logic signed [DEN_W-1:0] den_r;
  logic signed [CRD_W:0]   zh_r;
  logic                    geo_ok_r;

  logic signed [NUM_W-1:0] mcu_r, mcv_r, accu_r, accv_r;
  logic [SD_W-1:0]         sdsh_r;
  logic [NUM_W-1:0]        num_r;
  logic [DEN_W-1:0]        rem_r;
  logic                    neg_r;
  logic signed [Q_W-1:0]   u_r;

  logic [IDX_W-1:0]         u0_r, v0_r;
  logic [FRAC_W-1:0]        fu_r, fv_r;
  logic signed [PIX_W-1:0]  p_r [4];
  logic                     pcap_r;
  logic [1:0]               psel_r;
  logic signed [A_W-1:0]    a0_r, a1_r;
  logic signed [R_W-1:0]    r_r;

  logic signed [VAL_W-1:0] val_r;
  logic                    upd_r, sat_r;
  logic                    ovalid_r;
  logic [VAL_W-1:0]        odata_r;
  logic                    oupd_r, osat_r;

  // memories
  logic                vox_we, img_we;
  logic [VOL_AW-1:0]   vox_addr, vox_idx;
  logic [VAL_W-1:0]    vox_wdata, vox_rdata;
  logic [IMG_AW-1:0]   img_addr;
  logic [PIX_W-1:0]    img_rdata;

  cbvb_ram #(.WIDTH(VAL_W), .DEPTH(VOL_DEPTH)) u_vox_ram (
    .clk(clk), .we(vox_we), .addr(vox_addr), .wdata(vox_wdata), .rdata(vox_rdata)
  );

  cbvb_ram #(.WIDTH(PIX_W), .DEPTH(IMG_DEPTH)) u_img_ram (
    .clk(clk), .we(img_we), .addr(img_addr), .wdata(pval_r), .rdata(img_rdata)
  );

  // combinational helpers
  logic                     in_range, pix_in;
  logic signed [CRD_W-1:0]  x, y, z;
  logic signed [SQ_W-1:0]   sq_sum;
  logic signed [T_W-1:0]    t_nxt;
  logic signed [DEN_W-1:0]  s_ext, den_nxt;
  logic [DEN_W-1:0]         rem_sh, dvs;
  logic                     qbit;
  logic signed [Q_W-1:0]    qpos, qfl;
  logic signed [M_W-1:0]    um, vm;
  logic                     det_ok;
  logic [IDX_W-1:0]         pcol, prow;
  logic signed [WGT_W-1:0]  wu0, wu1, wv0, wv1;
  logic signed [A_W-1:0]    blend_a;
  logic signed [SUM_W-1:0]  sum;
  logic signed [VAL_W-1:0]  sum_sat;
  logic                     sum_clip;
  logic [1:0]               pidx;
  logic signed [PIX_W-1:0]  pa, pb;
  logic signed [NUM_W-1:0]  numv;

  assign in_range = (int'(vx_r) < IMAGE_WIDTH) && (int'(vy_r) < IMAGE_WIDTH) &&
                    (int'(vz_r) < IMAGE_HEIGHT);
  assign pix_in   = (int'(col_r) < IMAGE_WIDTH) && (int'(row_r) < IMAGE_HEIGHT);
  assign vox_idx  = VOL_AW'((int'(vx_r) * IMAGE_WIDTH + int'(vy_r)) * IMAGE_HEIGHT +
                            int'(vz_r));

  assign x = CRD_W'(signed'({1'b0, vx_r, 8'b0}) - (IMAGE_WIDTH * 128));
  assign y = CRD_W'(signed'({1'b0, vy_r, 8'b0}) - (IMAGE_WIDTH * 128));
  assign z = CRD_W'(signed'({1'b0, vz_r, 8'b0}) - (IMAGE_HEIGHT * 128));

  assign sq_sum  = sq_r + SQ_W'(pa_r) + SQ_W'(pb_r);
  assign t_nxt   = T_W'(pb_r) - T_W'(pa_r) + (T_W'(cfg.uoff) <<< ANG_SHIFT);
  assign s_ext   = DEN_W'(pa_r) + DEN_W'(pb_r);
  assign den_nxt = signed'(DEN_W'({cfg.sd, ANG_SHIFT'(0)})) - s_ext;

  // one restoring division step
  assign dvs    = den_r;
  assign rem_sh = {rem_r[DEN_W-2:0], num_r[NUM_W-1]};
  assign qbit   = (rem_sh >= dvs);

  // floor of the signed quotient
  assign qpos = signed'({1'b0, num_r});
  assign qfl  = neg_r ? (-qpos - Q_W'(rem_r != '0)) : qpos;

  assign um     = M_W'(u_r) + M_W'(IMAGE_WIDTH * 128);
  assign vm     = M_W'(IMAGE_HEIGHT * 128) - M_W'(qfl);
  assign det_ok = (um >= 0) && (um <= M_W'(UMAX)) && (vm >= 0) && (vm <= M_W'(VMAX));

  assign numv = accv_r <<< ANG_SHIFT;

  always_comb begin
    pidx = 2'd0;
    case (cmd.step)
      STEP_PRD1: pidx = 2'd1;
      STEP_PRD2: pidx = 2'd2;
      STEP_PRD3: pidx = 2'd3;
      default:   pidx = 2'd0;
    endcase
  end

  assign pcol = u0_r + IDX_W'(pidx[0]);
  assign prow = v0_r + IDX_W'(pidx[1]);

  assign wu1 = WGT_W'(fu_r);
  assign wu0 = WGT_W'(256) - wu1;
  assign wv1 = WGT_W'(fv_r);
  assign wv0 = WGT_W'(256) - wv1;
  assign pa  = (cmd.step == STEP_BL1) ? p_r[0] : p_r[2];
  assign pb  = (cmd.step == STEP_BL1) ? p_r[1] : p_r[3];
  assign blend_a = A_W'(pa) * A_W'(wu0) + A_W'(pb) * A_W'(wu1);

  assign sum      = SUM_W'(val_r) + SUM_W'(r_r >>> 16);
  assign sum_clip = (sum > SUM_W'(32'sh7fffffff)) || (sum < -SUM_W'(64'sh80000000));
  assign sum_sat  = (sum > SUM_W'(32'sh7fffffff)) ? 32'sh7fffffff :
                    (sum < -SUM_W'(64'sh80000000)) ? 32'sh80000000 : VAL_W'(sum);

  // memory ports
  always_comb begin
    vox_we    = 1'b0;
    vox_wdata = '0;
    vox_addr  = vox_idx;
    img_we    = 1'b0;
    img_addr  = IMG_AW'(int'(prow) * IMAGE_WIDTH + int'(pcol));
    case (cmd.step)
      STEP_CLR: begin
        vox_we   = 1'b1;
        vox_addr = clr_addr_r;
      end
      STEP_DISP: begin
        vox_we   = (op_r == OP_CLEAR) && in_range;
        img_we   = (op_r == OP_LOAD) && pix_in;
        img_addr = IMG_AW'(int'(row_r) * IMAGE_WIDTH + int'(col_r));
      end
      STEP_ACC: begin
        vox_we    = 1'b1;
        vox_wdata = sum_sat;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      ovalid_r   <= 1'b0;
      pcap_r     <= 1'b0;
    end else begin
      if (cmd.step == STEP_CLR) clr_addr_r <= clr_addr_r + 1'b1;
      pcap_r <= (cmd.step == STEP_PRD0) || (cmd.step == STEP_PRD1) ||
                (cmd.step == STEP_PRD2) || (cmd.step == STEP_PRD3);
      if (cmd.step == STEP_OUT && sts.out_free) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_op;
      col_r  <= in_col;
      row_r  <= in_row;
      pval_r <= in_pval;
      vx_r   <= in_vx;
      vy_r   <= in_vy;
      vz_r   <= in_vz;
      sin_r  <= in_sin;
      cos_r  <= in_cos;
      hoff_r <= in_hoff;
    end
    psel_r <= pidx;
    if (pcap_r) p_r[psel_r] <= img_rdata;

    case (cmd.step)
      STEP_DISP: begin
        val_r <= (in_range && (op_r == OP_BPROJ || op_r == OP_READ)) ? vox_rdata : '0;
        upd_r <= 1'b0;
        sat_r <= 1'b0;
        zh_r  <= (CRD_W + 1)'(z) + (CRD_W + 1)'(hoff_r);
      end
      STEP_GEO1: begin
        pa_r <= x * x;
        pb_r <= y * y;
        sq_r <= '0;
      end
      STEP_GEO2: begin
        sq_r <= sq_sum;
        pa_r <= x * sin_r;
        pb_r <= y * cos_r;
      end
      STEP_GEO3: begin
        t_r  <= t_nxt;
        pa_r <= x * cos_r;
        pb_r <= y * sin_r;
      end
      STEP_GEO4: begin
        den_r    <= den_nxt;
        geo_ok_r <= (sq_r < SQ_W'(CYL_R2)) && (den_nxt > 0);
      end
      STEP_TST: begin
        cnt_r  <= '0;
        accu_r <= '0;
        accv_r <= '0;
        mcu_r  <= NUM_W'(t_r);
        mcv_r  <= NUM_W'(zh_r);
        sdsh_r <= cfg.sd;
      end
      STEP_MUL: begin
        cnt_r  <= cnt_r + 1'b1;
        if (sdsh_r[0]) begin
          accu_r <= accu_r + mcu_r;
          accv_r <= accv_r + mcv_r;
        end
        mcu_r  <= mcu_r <<< 1;
        mcv_r  <= mcv_r <<< 1;
        sdsh_r <= sdsh_r >> 1;
      end
      STEP_DINU: begin
        cnt_r <= '0;
        rem_r <= '0;
        neg_r <= accu_r[NUM_W-1];
        num_r <= accu_r[NUM_W-1] ? unsigned'(-accu_r) : unsigned'(accu_r);
      end
      STEP_DINV: begin
        u_r   <= qfl;
        cnt_r <= '0;
        rem_r <= '0;
        neg_r <= numv[NUM_W-1];
        num_r <= numv[NUM_W-1] ? unsigned'(-numv) : unsigned'(numv);
      end
      STEP_DIVU, STEP_DIVV: begin
        cnt_r <= cnt_r + 1'b1;
        rem_r <= qbit ? (rem_sh - dvs) : rem_sh;
        num_r <= {num_r[NUM_W-2:0], qbit};
      end
      STEP_CHK: begin
        u0_r <= IDX_W'(um >>> FRAC_W);
        fu_r <= um[FRAC_W-1:0];
        v0_r <= IDX_W'(vm >>> FRAC_W);
        fv_r <= vm[FRAC_W-1:0];
      end
      STEP_BL1: a0_r <= blend_a;
      STEP_BL2: a1_r <= blend_a;
      STEP_BL3: r_r  <= R_W'(a0_r) * R_W'(wv0) + R_W'(a1_r) * R_W'(wv1);
      STEP_ACC: begin
        val_r <= sum_sat;
        upd_r <= 1'b1;
        sat_r <= sum_clip;
      end
      STEP_OUT: begin
        if (sts.out_free) begin
          odata_r <= val_r;
          oupd_r  <= upd_r;
          osat_r  <= sat_r;
        end
      end
      default: ;
    endcase
  end

  assign sts.op        = op_r;
  assign sts.in_range  = in_range;
  assign sts.geo_ok    = geo_ok_r;
  assign sts.iter_last = (cmd.step == STEP_MUL) ? (int'(cnt_r) == SD_W - 1)
                                                : (int'(cnt_r) == NUM_W - 1);
  assign sts.clr_last  = (int'(clr_addr_r) == VOL_DEPTH - 1);
  assign sts.det_ok    = det_ok;
  assign sts.out_free  = !ovalid_r || out_tready;

  assign out_tvalid = ovalid_r;
  assign out_value  = odata_r;
  assign out_upd    = oupd_r;
  assign out_sat    = osat_r;

  `CBVB_ASSERT(a_sat_implies_upd, sat_r |-> upd_r, "saturation flagged without update")
  `CBVB_ASSERT(a_sat_at_limit,
               (upd_r && sat_r) |-> (val_r == 32'sh7fffffff || val_r == 32'sh80000000),
               "saturated value not at a limit")
  `CBVB_ASSERT(a_out_loaded, (cmd.step == STEP_OUT && sts.out_free) |=> out_tvalid,
               "result not presented after output load")

endmodule

@@ sv/cone_beam_voxel_backprojection.sv @@
// Cone-beam voxel backprojection engine, fixed point, bilinear detector sampling.
// One transaction is handled at a time. A pixel load, voxel read or voxel clear
// passes the voxel read, dispatch and output states; a backprojection adds the
// geometry steps, the 24-step shift-add multiplier and two 60-step restoring
// divisions, plus four sequential reads of the single image memory port. After
// reset a clearing pass zeroes the 262144-entry voxel memory, one entry per
// cycle, during which in_tready stays low; apb writes are taken throughout.
// depends on cbvb_pkg, cbvb_ctrl, cbvb_datapath
`timescale 1ns / 1ps

module cone_beam_voxel_backprojection
  import cbvb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pixel_column, pixel_row, pixel_value, voxel_x, voxel_y, voxel_z, sine, cosine,
  // height_offset, two zero pad bits
  input  logic [103:0] in_tdata,
  // operation
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // voxel_value
  output logic [31:0]  out_tdata,
  // updated, saturated
  output logic [1:0]   out_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cmd_t cmd;
  sts_t sts;
  cfg_t cfg_r;
  logic wr_en;
  logic [VAL_W-1:0] value;
  logic upd, sat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sd   <= SD_RESET;
      cfg_r.uoff <= UOF_RESET;
    end else if (wr_en) begin
      if (int'(paddr[2]) == REG_SD)  cfg_r.sd   <= pwdata[SD_W-1:0];
      if (int'(paddr[2]) == REG_UOF) cfg_r.uoff <= pwdata[UOF_W-1:0];
    end
  end

  assign prdata = (int'(paddr[2]) == REG_SD) ? 32'(cfg_r.sd) : 32'(unsigned'(cfg_r.uoff));

  cbvb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .cmd(cmd), .sts(sts)
  );

  cbvb_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cfg(cfg_r),
    .in_op(op_t'(in_tuser)),
    .in_col(in_tdata[5:0]),
    .in_row(in_tdata[11:6]),
    .in_pval(in_tdata[35:12]),
    .in_vx(in_tdata[41:36]),
    .in_vy(in_tdata[47:42]),
    .in_vz(in_tdata[53:48]),
    .in_sin(in_tdata[69:54]),
    .in_cos(in_tdata[85:70]),
    .in_hoff(in_tdata[101:86]),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_value(value), .out_upd(upd), .out_sat(sat)
  );

  assign out_tdata = value;
  assign out_tuser = {sat, upd};

endmodule

@@ verif/tb_cone_beam_voxel_backprojection.sv @@
// self-checking testbench for cone_beam_voxel_backprojection: stream stimulus, apb setup,
// and a scoreboard class that predicts each voxel result from its own image and volume copy
// depends on cbvb_pkg and the cone_beam_voxel_backprojection rtl
`timescale 1ns / 1ps

module tb_cone_beam_voxel_backprojection;
  import cbvb_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    logic [31:0] value;
    logic        upd;
    logic        sat;
  } voxel_result_t;

  class voxel_tracker;
    logic signed [23:0] image [IMG_DEPTH];
    int                 volume [int];
    voxel_result_t      expected_voxels [$];
    logic [23:0]        sd;
    logic signed [15:0] uoff;
    int                 errors;

    function new();
      sd = 24'd256000;
      uoff = '0;
      errors = 0;
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    function longint pixel_at(longint col, longint row);
      return longint'(image[row * IMAGE_WIDTH + col]);
    endfunction

    function void note_input(op_t op, logic [103:0] d);
      voxel_result_t r;
      int idx;
      longint cur, x, y, z, sn, cs, hoff, t, s, den, u, v, um, vm;
      longint u0, fu, v0, fv, a0, a1, smp, sum;
      r.upd = 0;
      r.sat = 0;
      cur = 0;
      if (op == OP_LOAD) begin
        image[{d[11:6], d[5:0]}] = $signed(d[35:12]);
      end else begin
        idx = int'({d[41:36], d[47:42], d[53:48]});
        if (op == OP_CLEAR) volume[idx] = 0;
        cur = volume.exists(idx) ? volume[idx] : 0;
        if (op == OP_BPROJ) begin
          x = longint'(d[41:36]) * 256 - IMAGE_WIDTH * 128;
          y = longint'(d[47:42]) * 256 - IMAGE_WIDTH * 128;
          z = longint'(d[53:48]) * 256 - IMAGE_HEIGHT * 128;
          sn = longint'($signed(d[69:54]));
          cs = longint'($signed(d[85:70]));
          hoff = longint'($signed(d[101:86]));
          if (x * x + y * y < CYL_R2) begin
            t = -x * sn + y * cs + longint'(uoff) * 16384;
            s = x * cs + y * sn;
            den = longint'(sd) * 16384 - s;
            if (den > 0) begin
              u = floor_div(t * longint'(sd), den);
              v = floor_div((z + hoff) * longint'(sd) * 16384, den);
              um = u + IMAGE_WIDTH * 128;
              vm = IMAGE_HEIGHT * 128 - v;
              if (um >= 0 && um <= UMAX && vm >= 0 && vm <= VMAX) begin
                u0 = um / 256;
                fu = um % 256;
                v0 = vm / 256;
                fv = vm % 256;
                a0 = pixel_at(u0, v0) * (256 - fu) + pixel_at(u0 + 1, v0) * fu;
                a1 = pixel_at(u0, v0 + 1) * (256 - fu) + pixel_at(u0 + 1, v0 + 1) * fu;
                smp = (a0 * (256 - fv) + a1 * fv) >>> 16;
                sum = cur + smp;
                if (sum > 64'sd2147483647) begin
                  sum = 64'sd2147483647;
                  r.sat = 1;
                end
                if (sum < -64'sd2147483648) begin
                  sum = -64'sd2147483648;
                  r.sat = 1;
                end
                volume[idx] = int'(sum);
                cur = sum;
                r.upd = 1;
              end
            end
          end
        end
      end
      r.value = cur[31:0];
      expected_voxels.insert(expected_voxels.size(), r);
    endfunction

    task report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $time);
      errors++;
    endtask

    task check_result(logic [31:0] value, logic upd, logic sat);
      voxel_result_t e;
      if (expected_voxels.size() == 0) begin
        report("unexpected transaction", 0, value);
      end else begin
        e = expected_voxels.pop_front();
        if (value !== e.value) report("voxel_value", e.value, value);
        if (upd !== e.upd) report("updated", e.upd, upd);
        if (sat !== e.sat) report("saturated", e.sat, sat);
      end
    endtask
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;    // pixel_column, pixel_row, pixel_value, voxel_x, voxel_y,
                                  // voxel_z, sine, cosine, height_offset, pad
  logic [1:0]   in_tuser = '0;    // operation
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [31:0]  out_tdata;        // voxel_value
  logic [1:0]   out_tuser;        // updated, saturated
  logic         psel = 0;
  logic         penable = 0;
  logic         pwrite = 0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  voxel_tracker tracker = new();
  bit           no_idle = 0;
  int           results_seen = 0;
  int           quiet_cycles = 0;

  always #2 clk = ~clk;

  cone_beam_voxel_backprojection uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) tracker.note_input(op_t'(in_tuser), in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(out_tdata, out_tuser[0], out_tuser[1]);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL cone_beam_voxel_backprojection");
      $finish;
    end
  end

  // result side: random stalls plus one long hold to back up the input
  initial begin
    bit held;
    held = 0;
    forever begin
      if (!no_idle && !held && results_seen >= 600) begin
        held = 1;
        out_tready <= 0;
        repeat (600) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [103:0] pack_item(
      logic [5:0] col, logic [5:0] row, logic [23:0] pval, logic [5:0] vx, logic [5:0] vy,
      logic [5:0] vz, logic [15:0] sn, logic [15:0] cs, logic [15:0] hoff);
    return {2'b00, hoff, cs, sn, vz, vy, vx, pval, row, col};
  endfunction

  task send_item(input op_t op, input logic [103:0] d);
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= d;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task load_pixel(input logic [5:0] col, input logic [5:0] row, input logic [23:0] pval);
    send_item(OP_LOAD, pack_item(col, row, pval, 6'($urandom), 6'($urandom), 6'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  task voxel_op(input op_t op, input logic [5:0] vx, input logic [5:0] vy, input logic [5:0] vz,
                input logic [15:0] sn, input logic [15:0] cs, input logic [15:0] hoff);
    send_item(op, pack_item(6'($urandom), 6'($urandom), 24'($urandom), vx, vy, vz,
                            sn, cs, hoff));
  endtask

  task write_reg(input int idx, input logic [31:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= 3'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == REG_SD) tracker.sd = val[23:0];
    else tracker.uoff = val[15:0];
  endtask

  task wait_idle();
    in_tvalid <= 0;
    while (tracker.expected_voxels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // height offset cancels the voxel height so samples stay in detector rows 30 to 34
  task random_item();
    int    pick;
    int    delta;
    real   ang;
    logic [15:0] sn, cs, hoff;
    logic [5:0]  vx, vy, vz;
    pick = $urandom_range(0, 99);
    ang = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
    sn = 16'($rtoi(16384.0 * $sin(ang)));
    cs = 16'($rtoi(16384.0 * $cos(ang)));
    if ($urandom_range(0, 9) == 0) begin
      sn = 16'($urandom);
      cs = 16'($urandom);
    end
    vz = 6'($urandom);
    delta = (tracker.sd >= 24'd65536) ? int'($urandom_range(0, 512)) - 256 : 0;
    hoff = 16'((32 - int'(vz)) * 256 + delta);
    vx = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(6, 57));
    vy = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(6, 57));
    if (pick < 70) voxel_op(OP_BPROJ, vx, vy, vz, sn, cs, hoff);
    else if (pick < 80) load_pixel(6'($urandom), 6'($urandom), 24'($urandom));
    else if (pick < 90) voxel_op(OP_READ, vx, vy, 6'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom));
    else voxel_op(OP_CLEAR, vx, vy, 6'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
  endtask

  initial begin
    logic [23:0] sd_list [5];
    logic [15:0] uoff_list [5];
    sd_list = '{24'd256000, 24'hFFFFFF, 24'd0, 24'd256, 24'd2560};
    uoff_list = '{16'h0000, 16'h7FFF, 16'h8000, 16'($urandom), 16'hFF00};
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_reg(REG_SD, 32'(sd_list[0]));
    write_reg(REG_UOF, 32'(uoff_list[0]));

    // fill detector rows 31 to 34; later samples reach rows 30 to 34
    for (int p = 0; p < 4 * IMAGE_WIDTH; p++)
      load_pixel(6'(p % 64), 6'(31 + p / 64), 24'($urandom));

    // directed corners and special cases
    load_pixel(6'd63, 6'd63, 24'h7FFFFF);
    load_pixel(6'd0, 6'd0, 24'h800000);
    voxel_op(OP_BPROJ, 6'd0, 6'd0, 6'd0, 16'h0000, 16'h4000, 16'h0000);
    voxel_op(OP_BPROJ, 6'd63, 6'd63, 6'd63, 16'h4000, 16'h0000, 16'h0000);
    voxel_op(OP_BPROJ, 6'd32, 6'd32, 6'd32, 16'h0000, 16'h4000, 16'h0000);
    voxel_op(OP_BPROJ, 6'd32, 6'd32, 6'd32, 16'hC000, 16'h0000, 16'h7FFF);
    voxel_op(OP_BPROJ, 6'd32, 6'd32, 6'd32, 16'h4000, 16'hC000, 16'h8000);
    voxel_op(OP_BPROJ, 6'd10, 6'd50, 6'd0, 16'h2D41, 16'h2D41, 16'h0000);
    voxel_op(OP_BPROJ, 6'd55, 6'd20, 6'd63, 16'hD2BF, 16'h2D41, 16'h0100);
    voxel_op(OP_BPROJ, 6'd6, 6'd32, 6'd31, 16'h0000, 16'hC000, 16'h0100);
    voxel_op(OP_READ, 6'd32, 6'd32, 6'd32, 16'h0000, 16'h0000, 16'h0000);
    voxel_op(OP_READ, 6'd63, 6'd63, 6'd63, 16'h0000, 16'h0000, 16'h0000);
    voxel_op(OP_CLEAR, 6'd32, 6'd32, 6'd32, 16'h0000, 16'h0000, 16'h0000);
    voxel_op(OP_READ, 6'd32, 6'd32, 6'd32, 16'h0000, 16'h0000, 16'h0000);
    voxel_op(OP_CLEAR, 6'd0, 6'd0, 6'd0, 16'h0000, 16'h0000, 16'h0000);

    // drive one voxel into the positive and then the negative limit
    load_pixel(6'd32, 6'd32, 24'h7FFFFF);
    voxel_op(OP_CLEAR, 6'd32, 6'd32, 6'd32, 16'h0000, 16'h0000, 16'h0000);
    repeat (258) voxel_op(OP_BPROJ, 6'd32, 6'd32, 6'd32, 16'h0000, 16'h4000, 16'h0000);
    load_pixel(6'd32, 6'd32, 24'h800000);
    voxel_op(OP_CLEAR, 6'd32, 6'd32, 6'd32, 16'h0000, 16'h0000, 16'h0000);
    repeat (258) voxel_op(OP_BPROJ, 6'd32, 6'd32, 6'd32, 16'h0000, 16'h4000, 16'h0000);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_reg(REG_SD, 32'(sd_list[ph]));
        write_reg(REG_UOF, 32'(uoff_list[ph]));
      end
      if (ph == 4) no_idle = 1;
      repeat (200) random_item();
    end
    in_tvalid <= 0;

    while (tracker.expected_voxels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_voxels.size() == 0)
      $display("PASS cone_beam_voxel_backprojection");
    else
      $display("FAIL cone_beam_voxel_backprojection");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/cbvb_pkg.sv
sv/cbvb_ram.sv
sv/cbvb_ctrl.sv
sv/cbvb_datapath.sv
sv/cone_beam_voxel_backprojection.sv
verif/tb_cone_beam_voxel_backprojection.sv
